FILE: sv/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the particle pool update unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  localparam logic [2:0] REG_GRAVITY_X  = 3'd0;
  localparam logic [2:0] REG_GRAVITY_Y  = 3'd1;
  localparam logic [2:0] REG_DRAG       = 3'd2;
  localparam logic [2:0] REG_LIFETIME   = 3'd3;
  localparam logic [2:0] REG_START_COL  = 3'd4;
  localparam logic [2:0] REG_END_COL    = 3'd5;
  localparam logic [2:0] REG_SCALE_TGT  = 3'd6;
  localparam logic [2:0] REG_SCALE_EN   = 3'd7;

  localparam int DIV_STEPS = 50;  // quotient bits of the lerp divider

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_READ,
    ST_VEL,
    ST_DRAG,
    ST_POS,
    ST_DIV,
    ST_EMIT,
    ST_NEXT,
    ST_DONE
  } ppu_state_t;

  typedef struct packed {
    logic spawn_wr;     // commit spawn into the slot chosen
    logic rd;           // read slot at walk index
    logic vel;          // add gravity
    logic drag;         // multiply by drag
    logic pos;          // integrate, latch lerp operands
    logic div_start;    // launch divider
    logic emit_draw;    // load draw record
    logic emit_ack;     // load spawn record
    logic emit_frame;   // load frame-done record
    logic retire;       // clear live bit
    logic walk_clr;     // reset walk index
    logic walk_inc;     // step walk index
    logic frame_end;    // rebuild free map, bump frame counter
  } ppu_cmd_t;

  typedef struct packed {
    logic walk_done;    // walk index reached used count
    logic slot_live;
    logic slot_expired;
    logic div_busy;
  } ppu_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

FILE: sv/ppu_ctrl.sv
// ----------------------------------------------------------------------------
// ppu_ctrl
// Sequencer for spawn and tick transactions.
// ----------------------------------------------------------------------------
module ppu_ctrl
  import ppu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_go,
  input  logic     in_func,
  input  logic     out_free,
  input  ppu_sts_t sts,
  output logic     busy,
  output ppu_cmd_t cmd
);

  ppu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_go) state_next = in_func ? ST_READ : ST_SPAWN;
      ST_SPAWN: if (out_free) state_next = ST_IDLE;
      ST_READ: begin
        if (sts.walk_done) state_next = ST_DONE;
        else state_next = ST_VEL;
      end
      ST_VEL: begin
        if (!sts.slot_live || sts.slot_expired) state_next = ST_NEXT;
        else state_next = ST_DRAG;
      end
      ST_DRAG:  state_next = ST_POS;
      ST_POS:   state_next = ST_DIV;
      ST_DIV:   if (!sts.div_busy) state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_NEXT;
      ST_NEXT:  state_next = ST_READ;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE:  cmd.walk_clr = 1'b1;
      ST_SPAWN: begin
        cmd.emit_ack = out_free;
        cmd.spawn_wr = out_free;
      end
      ST_READ:  cmd.rd = 1'b1;
      ST_VEL: begin
        cmd.vel = 1'b1;
        cmd.retire = sts.slot_live && sts.slot_expired;
      end
      ST_DRAG:  cmd.drag = 1'b1;
      ST_POS: begin
        cmd.pos = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_EMIT:  cmd.emit_draw = out_free;
      ST_NEXT:  cmd.walk_inc = 1'b1;
      ST_DONE: begin
        cmd.emit_frame = out_free;
        cmd.frame_end = out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/ppu_div.sv
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider, one quotient bit per cycle, floor semantics on a
// signed dividend and positive 16-bit divisor. Five dividends share it
// (scale and four colors) by running them in lanes.
// ----------------------------------------------------------------------------
module ppu_div
  import ppu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [49:0] num [5],
  input  logic [15:0]        den,
  output logic               busy,
  output logic signed [49:0] quo [5]
);

  logic [5:0]  cnt;
  logic [49:0] mag [5];
  logic [49:0] q   [5];
  logic [16:0] rem [5];
  logic        neg [5];
  logic        nz  [5];
  logic [15:0] d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) d <= den;
    for (int l = 0; l < 5; l++) begin
      if (start) begin
        neg[l] <= num[l][49];
        mag[l] <= num[l][49] ? 50'(-num[l]) : num[l];
        rem[l] <= '0;
        q[l]   <= '0;
      end else if (busy) begin
        logic [16:0] t;
        t = {rem[l][15:0], mag[l][49]};
        mag[l] <= {mag[l][48:0], 1'b0};
        if (t >= {1'b0, d}) begin
          rem[l] <= t - {1'b0, d};
          q[l]   <= {q[l][48:0], 1'b1};
        end else begin
          rem[l] <= t;
          q[l]   <= {q[l][48:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 5; l++) begin
      nz[l]  = (rem[l] != '0);
      quo[l] = neg[l] ? ($signed(-q[l]) - (nz[l] ? 50'sd1 : 50'sd0)) : $signed(q[l]);
    end
  end

endmodule

FILE: sv/ppu_dp.sv
// ----------------------------------------------------------------------------
// ppu_dp
// Slot store, physics arithmetic, free map and result register.
// ----------------------------------------------------------------------------
module ppu_dp
  import ppu_pkg::*;
#(
  parameter int MAX_PARTICLES = 32,
  parameter int IDX_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  ppu_cmd_t           cmd,
  output ppu_sts_t           sts,
  input  logic signed [31:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y,
  input  logic signed [31:0] in_rot, in_spin, in_scale,
  input  logic signed [31:0] gravity_x, gravity_y, scale_target,
  input  logic [31:0]        drag_factors, start_color, end_color,
  input  logic [15:0]        lifetime_frames,
  input  logic               scale_target_en,
  input  logic               out_load_ok,
  output logic               out_valid_set,
  output logic [1:0]         r_kind,
  output logic [5:0]         r_slot,
  output logic               r_dropped,
  output logic signed [31:0] r_pos_x, r_pos_y, r_rot, r_scale,
  output logic [7:0]         r_red, r_green, r_blue, r_alpha,
  output logic               r_last
);

  logic signed [31:0] m_px [MAX_PARTICLES];
  logic signed [31:0] m_py [MAX_PARTICLES];
  logic signed [31:0] m_vx [MAX_PARTICLES];
  logic signed [31:0] m_vy [MAX_PARTICLES];
  logic signed [31:0] m_an [MAX_PARTICLES];
  logic signed [31:0] m_sp [MAX_PARTICLES];
  logic signed [31:0] m_bs [MAX_PARTICLES];
  logic [31:0]        m_bf [MAX_PARTICLES];

  logic [MAX_PARTICLES-1:0] live, reuse;
  logic [5:0]  used, walk;
  logic [31:0] frame_count;

  logic signed [31:0] px, py, vx, vy, an, sp, bs;
  logic [31:0] age;
  logic [15:0] life;
  logic [15:0] lin_f, ang_f;
  logic signed [63:0] pvx, pvy, psp;

  logic               dv_busy;
  logic signed [49:0] dv_num [5];
  logic signed [49:0] dv_quo [5];
  logic signed [31:0] l_base;
  logic [7:0]         l_sc [4];

  logic [IDX_W-1:0] widx;
  logic [5:0]       pick;
  logic             pick_ok;
  logic [5:0]       spawn_slot;

  assign widx = walk[IDX_W-1:0];
  assign life = (lifetime_frames == 16'd0) ? 16'd1 : lifetime_frames;
  assign lin_f = (drag_factors[15:0] > 16'd32768) ? 16'd32768 : drag_factors[15:0];
  assign ang_f = (drag_factors[31:16] > 16'd32768) ? 16'd32768 : drag_factors[31:16];

  assign sts.walk_done    = (walk >= used);
  assign sts.slot_live    = live[widx];
  assign sts.slot_expired = (age >= {16'd0, life});
  assign sts.div_busy     = dv_busy;

  // lowest reusable slot
  always_comb begin
    pick = 6'(MAX_PARTICLES);
    for (int i = MAX_PARTICLES - 1; i >= 0; i--) if (reuse[i]) pick = 6'(i);
    pick_ok = (pick < 6'(MAX_PARTICLES)) || (used < 6'(MAX_PARTICLES));
  end

  // freed slot first, else the next never-used one
  assign spawn_slot = (pick < 6'(MAX_PARTICLES)) ? pick : used;

  function automatic logic signed [31:0] drag_q(input logic signed [63:0] p);
    return sat32(66'(p >>> 15));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      px <= m_px[widx]; py <= m_py[widx]; vx <= m_vx[widx]; vy <= m_vy[widx];
      an <= m_an[widx]; sp <= m_sp[widx]; bs <= m_bs[widx];
      age <= frame_count - m_bf[widx];
    end
    if (cmd.vel) begin
      vx <= sat32(66'(vx) + 66'(gravity_x));
      vy <= sat32(66'(vy) + 66'(gravity_y));
    end
    if (cmd.drag) begin
      pvx <= vx * $signed({1'b0, lin_f});
      pvy <= vy * $signed({1'b0, lin_f});
      psp <= sp * $signed({1'b0, ang_f});
    end
    if (cmd.pos) begin
      m_vx[widx] <= drag_q(pvx);
      m_vy[widx] <= drag_q(pvy);
      m_sp[widx] <= drag_q(psp);
      px <= sat32(66'(px) + 66'(drag_q(pvx)));
      py <= sat32(66'(py) + 66'(drag_q(pvy)));
      an <= sat32(66'(an) + 66'(drag_q(psp)));
      m_px[widx] <= sat32(66'(px) + 66'(drag_q(pvx)));
      m_py[widx] <= sat32(66'(py) + 66'(drag_q(pvy)));
      m_an[widx] <= sat32(66'(an) + 66'(drag_q(psp)));
    end
    if (cmd.spawn_wr && pick_ok) begin
      m_px[spawn_slot[IDX_W-1:0]] <= in_pos_x;
      m_py[spawn_slot[IDX_W-1:0]] <= in_pos_y;
      m_vx[spawn_slot[IDX_W-1:0]] <= in_vel_x;
      m_vy[spawn_slot[IDX_W-1:0]] <= in_vel_y;
      m_an[spawn_slot[IDX_W-1:0]] <= in_rot;
      m_sp[spawn_slot[IDX_W-1:0]] <= in_spin;
      m_bs[spawn_slot[IDX_W-1:0]] <= in_scale;
      m_bf[spawn_slot[IDX_W-1:0]] <= frame_count;
    end
  end

  // lerp numerators: (end - start) * age, age < life <= 65535
  always_comb begin
    logic signed [32:0] dsc;
    logic signed [8:0]  dc;
    dsc = scale_target_en ? (33'(scale_target) - 33'(bs)) : 33'sd0;
    dv_num[0] = 50'(dsc) * 50'($signed({1'b0, age[15:0]}));
    for (int c = 0; c < 4; c++) begin
      dc = $signed({1'b0, end_color[31-8*c -: 8]}) - $signed({1'b0, start_color[31-8*c -: 8]});
      dv_num[c+1] = 50'(dc) * 50'($signed({1'b0, age[15:0]}));
    end
  end

  ppu_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(dv_num),
    .den(life), .busy(dv_busy), .quo(dv_quo)
  );

  always_comb begin
    l_base = sat32(66'(bs) + 66'(dv_quo[0]));
    for (int c = 0; c < 4; c++)
      l_sc[c] = 8'(50'(start_color[31-8*c -: 8]) + dv_quo[c+1]);
  end

  assign out_valid_set = out_load_ok && (cmd.emit_ack || cmd.emit_draw || cmd.emit_frame);

  always_ff @(posedge clk) begin
    if (out_valid_set) begin
      r_kind <= cmd.emit_ack ? KIND_ACK : (cmd.emit_draw ? KIND_DRAW : KIND_FRAME);
      r_slot <= cmd.emit_draw ? walk : ((cmd.emit_ack && pick_ok) ? spawn_slot : 6'd0);
      r_dropped <= cmd.emit_ack && !pick_ok;
      r_last <= !cmd.emit_draw;
      r_pos_x <= cmd.emit_draw ? px : 32'sd0;
      r_pos_y <= cmd.emit_draw ? py : 32'sd0;
      r_rot   <= cmd.emit_draw ? an : 32'sd0;
      r_scale <= cmd.emit_draw ? l_base : 32'sd0;
      r_red   <= cmd.emit_draw ? l_sc[0] : 8'd0;
      r_green <= cmd.emit_draw ? l_sc[1] : 8'd0;
      r_blue  <= cmd.emit_draw ? l_sc[2] : 8'd0;
      r_alpha <= cmd.emit_draw ? l_sc[3] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0; reuse <= '0; used <= '0; frame_count <= '0; walk <= '0;
    end else begin
      if (cmd.walk_clr) walk <= '0;
      else if (cmd.walk_inc) walk <= walk + 6'd1;
      if (cmd.retire) live[widx] <= 1'b0;
      if (cmd.spawn_wr && pick_ok) begin
        live[spawn_slot[IDX_W-1:0]] <= 1'b1;
        if (pick < 6'(MAX_PARTICLES)) reuse[pick[IDX_W-1:0]] <= 1'b0;
        else used <= used + 6'd1;
      end
      if (cmd.frame_end) begin
        for (int i = 0; i < MAX_PARTICLES; i++)
          reuse[i] <= (6'(i) < used) && !live[i];
        frame_count <= frame_count + 32'd1;
      end
    end
  end

endmodule

FILE: sv/particle_pool_update_unit.sv
// ----------------------------------------------------------------------------
// particle_pool_update_unit
// Fixed particle pool: spawn places one particle, tick walks all used slots.
// ----------------------------------------------------------------------------
// Spawn: ack record loaded once the output register is free; next input after it.
// Tick: each used slot is read; a dead or expiring one is skipped, a live one takes
//   gravity, drag, position and the shared bit-serial lerp divider (50 quotient
//   bits) before its draw record, then a frame-done record; stalls hold each load.
// One item at a time; the next is taken once the last record is loaded.
// Reset (rst, synchronous) stalls input, clears live/free maps, used count,
//   frame counter and config to defaults; slot storage is not cleared.
module particle_pool_update_unit
  import ppu_pkg::*;
#(
  parameter int MAX_PARTICLES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] spawn_pos_x,
  input  logic signed [31:0] spawn_pos_y,
  input  logic signed [31:0] spawn_vel_x,
  input  logic signed [31:0] spawn_vel_y,
  input  logic signed [31:0] spawn_rotation,
  input  logic signed [31:0] spawn_spin,
  input  logic signed [31:0] spawn_scale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         record_kind,
  output logic [5:0]         slot,
  output logic               dropped,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] rotation,
  output logic signed [31:0] scale,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic               last
);

  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  // config registers
  logic signed [31:0] gravity_x, gravity_y, scale_target;
  logic [31:0]        drag_factors, start_color, end_color;
  logic [15:0]        lifetime_frames;
  logic               scale_target_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_x <= '0; gravity_y <= '0;
      drag_factors <= 32'h8000_8000; lifetime_frames <= 16'd1;
      start_color <= '1; end_color <= '1;
      scale_target <= 32'sh0001_0000; scale_target_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAVITY_X: gravity_x <= cfg_data;
        REG_GRAVITY_Y: gravity_y <= cfg_data;
        REG_DRAG:      drag_factors <= cfg_data;
        REG_LIFETIME:  lifetime_frames <= cfg_data[15:0];
        REG_START_COL: start_color <= cfg_data;
        REG_END_COL:   end_color <= cfg_data;
        REG_SCALE_TGT: scale_target <= cfg_data;
        REG_SCALE_EN:  scale_target_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input capture: payload held in a register for the whole transaction
  logic               busy, in_go, item_func;
  logic signed [31:0] h_px, h_py, h_vx, h_vy, h_rot, h_spin, h_scale;

  assign in_stall = busy || rst;
  assign in_go = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_go) begin
      item_func <= func;
      h_px <= spawn_pos_x; h_py <= spawn_pos_y;
      h_vx <= spawn_vel_x; h_vy <= spawn_vel_y;
      h_rot <= spawn_rotation; h_spin <= spawn_spin; h_scale <= spawn_scale;
    end
  end

  // output register: free when empty or being taken this cycle
  logic     out_free, out_set;
  ppu_cmd_t cmd;
  ppu_sts_t sts;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  ppu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_go), .in_func(func), .out_free(out_free),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  ppu_dp #(.MAX_PARTICLES(MAX_PARTICLES), .IDX_W(IDX_W)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_pos_x(h_px), .in_pos_y(h_py), .in_vel_x(h_vx), .in_vel_y(h_vy),
    .in_rot(h_rot), .in_spin(h_spin), .in_scale(h_scale),
    .gravity_x(gravity_x), .gravity_y(gravity_y), .scale_target(scale_target),
    .drag_factors(drag_factors), .start_color(start_color), .end_color(end_color),
    .lifetime_frames(lifetime_frames), .scale_target_en(scale_target_en),
    .out_load_ok(out_free), .out_valid_set(out_set),
    .r_kind(record_kind), .r_slot(slot), .r_dropped(dropped),
    .r_pos_x(pos_x), .r_pos_y(pos_y), .r_rot(rotation), .r_scale(scale),
    .r_red(red), .r_green(green), .r_blue(blue), .r_alpha(alpha), .r_last(last)
  );

  // a spawn transaction only ever yields an ack record
  a_spawn_ack: assert property (@(posedge clk) disable iff (rst)
    out_set && !item_func |=> record_kind == KIND_ACK && last)
    else $error("spawn produced non-ack record");

  // draw records are never marked last
  a_draw_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == KIND_DRAW |-> !last)
    else $error("draw record marked last");

  // no new item while a transaction is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("input accepted while busy");

endmodule

FILE: bench/particle_pool_update_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_pool_update_unit_tb
// Self-checking bench for the particle pool update unit. A scoreboard keeps
// its own copy of the pool, predicts the ack, draw and frame-done records
// of every accepted transaction and checks each output record in order.
// Stimulus is a directed warm-up followed by random phases under random
// configurations, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module particle_pool_update_unit_tb;
  import ppu_pkg::*;

  localparam int POOL       = 32;
  localparam int IDLE_LIMIT = 20000;  // cycles with no transaction at all
  localparam int HOLD_LEN   = 400;    // long receiver hold-off
  localparam int DRAIN_WAIT = 100;    // settle time after the last record

  localparam logic FUNC_SPAWN = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic signed [31:0] spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y;
  logic signed [31:0] spawn_rotation, spawn_spin, spawn_scale;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         record_kind;
  logic [5:0]         slot;
  logic               dropped;
  logic signed [31:0] pos_x, pos_y, rotation, scale;
  logic [7:0]         red, green, blue, alpha;
  logic               last;

  int  mismatch_cnt = 0;
  int  idle_cycles  = 0;
  bit  hold_req     = 0;

  particle_pool_update_unit dut (.*);

  // one output record
  typedef struct {
    logic [1:0]         kind;
    logic [5:0]         slot;
    logic               drop;
    logic signed [31:0] px, py, rot, sc;
    logic [7:0]         r, g, b, a;
    logic               lst;
  } record_t;

  // one spawn payload
  typedef struct {
    logic signed [31:0] px, py, vx, vy, rot, spin, sc;
  } spawn_t;

  task automatic report(input string msg);
    mismatch_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: pool predictor plus queue of pending records.
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic signed [31:0] grav_x, grav_y, end_sc;
    logic [31:0]        drag, start_col, end_col;
    logic [15:0]        life_reg;
    bit                 scale_en;
    bit                 live[POOL];
    bit                 reuse[POOL];
    int unsigned        used;
    logic [31:0]        frame;
    logic [31:0]        birth[POOL];
    logic signed [31:0] px[POOL], py[POOL], vx[POOL], vy[POOL];
    logic signed [31:0] ang[POOL], spn[POOL], bsc[POOL];
    record_t            pending_q[$];

    function new();
      grav_x = 0; grav_y = 0; drag = 32'h8000_8000; life_reg = 16'd1;
      start_col = '1; end_col = '1; end_sc = 32'sh0001_0000; scale_en = 0;
      used = 0; frame = 0;
      foreach (live[i]) begin
        live[i] = 0;
        reuse[i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_GRAVITY_X: grav_x = val;
        REG_GRAVITY_Y: grav_y = val;
        REG_DRAG:      drag = val;
        REG_LIFETIME:  life_reg = val[15:0];
        REG_START_COL: start_col = val;
        REG_END_COL:   end_col = val;
        REG_SCALE_TGT: end_sc = val;
        REG_SCALE_EN:  scale_en = val[0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] sat(longint x);
      if (x > 64'sd2147483647) return 32'sh7fff_ffff;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    // factors above one count as one
    function logic signed [31:0] damp(logic signed [31:0] v, logic [15:0] f);
      longint ff;
      ff = (f > 16'd32768) ? 32768 : longint'(f);
      return sat(floor_div(longint'(v) * ff, 32768));
    endfunction

    function longint lerp(longint s, longint e, longint age, longint life);
      return s + floor_div((e - s) * age, life);
    endfunction

    function record_t blank(logic [1:0] kind);
      record_t rec;
      rec = '{kind: kind, slot: 0, drop: 0, px: 0, py: 0, rot: 0, sc: 0,
              r: 0, g: 0, b: 0, a: 0, lst: 0};
      return rec;
    endfunction

    function void note_spawn(spawn_t sp);
      record_t rec;
      int s;
      s = -1;
      rec = blank(KIND_ACK);
      rec.lst = 1;
      for (int i = 0; i < POOL; i++)
        if (s < 0 && reuse[i]) s = i;
      if (s >= 0) reuse[s] = 0;
      else if (used < POOL) begin
        s = used;
        used++;
      end
      if (s < 0) begin
        rec.drop = 1;  // pool full
      end else begin
        live[s] = 1; birth[s] = frame;
        px[s] = sp.px; py[s] = sp.py; vx[s] = sp.vx; vy[s] = sp.vy;
        ang[s] = sp.rot; spn[s] = sp.spin; bsc[s] = sp.sc;
        rec.slot = 6'(s);
      end
      pending_q = {pending_q, rec};
    endfunction

    function void note_tick();
      record_t rec;
      longint life, age, tgt;
      logic [31:0] age_w;
      logic [7:0] cs[4], ce[4], cv[4];
      life = (life_reg == 0) ? 1 : longint'(life_reg);
      for (int i = 0; i < used; i++) begin
        if (!live[i]) continue;
        age_w = frame - birth[i];
        age = longint'(age_w);
        if (age >= life) begin
          live[i] = 0;
          continue;
        end
        vx[i] = damp(sat(longint'(vx[i]) + longint'(grav_x)), drag[15:0]);
        vy[i] = damp(sat(longint'(vy[i]) + longint'(grav_y)), drag[15:0]);
        spn[i] = damp(spn[i], drag[31:16]);
        px[i] = sat(longint'(px[i]) + longint'(vx[i]));
        py[i] = sat(longint'(py[i]) + longint'(vy[i]));
        ang[i] = sat(longint'(ang[i]) + longint'(spn[i]));
        tgt = scale_en ? longint'(end_sc) : longint'(bsc[i]);
        rec = blank(KIND_DRAW);
        rec.slot = 6'(i);
        rec.px = px[i]; rec.py = py[i]; rec.rot = ang[i];
        rec.sc = sat(lerp(longint'(bsc[i]), tgt, age, life));
        for (int c = 0; c < 4; c++) begin
          cs[c] = start_col[31 - 8*c -: 8];
          ce[c] = end_col[31 - 8*c -: 8];
          cv[c] = 8'(lerp(longint'(cs[c]), longint'(ce[c]), age, life));
        end
        rec.r = cv[0]; rec.g = cv[1]; rec.b = cv[2]; rec.a = cv[3];
        pending_q = {pending_q, rec};
      end
      rec = blank(KIND_FRAME);
      rec.lst = 1;
      pending_q = {pending_q, rec};
      for (int i = 0; i < POOL; i++) reuse[i] = (i < used) && !live[i];
      frame++;
    endfunction

    function void note_input(logic fn, spawn_t sp);
      if (fn == FUNC_SPAWN) note_spawn(sp);
      else note_tick();
    endfunction

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(record_t got);
      record_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected record kind %0d slot %0d", got.kind, got.slot));
        return;
      end
      want = pending_q.pop_front();
      cmp("record_kind", got.kind, want.kind);
      cmp("slot", got.slot, want.slot);
      cmp("dropped", got.drop, want.drop);
      cmp("pos_x", got.px, want.px);
      cmp("pos_y", got.py, want.py);
      cmp("rotation", got.rot, want.rot);
      cmp("scale", got.sc, want.sc);
      cmp("red", got.r, want.r);
      cmp("green", got.g, want.g);
      cmp("blue", got.b, want.b);
      cmp("alpha", got.a, want.a);
      cmp("last", got.lst, want.lst);
    endtask
  endclass

  pool_scoreboard sb = new();

  // --------------------------------------------------------------------------
  // Clock, watchdog, output monitor
  // --------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sampled at the edge, before the DUT's own updates land
  always @(posedge clk) begin
    record_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind: record_kind, slot: slot, drop: dropped, px: pos_x, py: pos_y,
              rot: rotation, sc: scale, r: red, g: green, b: blue, a: alpha,
              lst: last};
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern changes every window; a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int mode, win;
    out_stall = 0;
    mode = 0;
    win = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_req = 0;
        out_stall = 0;
      end else begin
        if (win == 0) begin
          win = $urandom_range(10, 80);
          mode = $urandom_range(0, 3);
        end
        win--;
        case (mode)
          0: out_stall = 0;                         // free flowing
          1: out_stall = ($urandom_range(0, 9) < 3);
          2: out_stall = ($urandom_range(0, 9) < 8);
          default: out_stall = (win % 4 != 0);      // periodic
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // one transaction; valid stays high while the burst continues
  task automatic send(input logic fn, input spawn_t sp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    func = fn;
    spawn_pos_x = sp.px; spawn_pos_y = sp.py;
    spawn_vel_x = sp.vx; spawn_vel_y = sp.vy;
    spawn_rotation = sp.rot; spawn_spin = sp.spin; spawn_scale = sp.sc;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(fn, sp);
  endtask

  task automatic tick();
    spawn_t sp;
    sp = '{px: $urandom, py: $urandom, vx: $urandom, vy: $urandom,
           rot: $urandom, spin: $urandom, sc: $urandom};
    send(FUNC_TICK, sp);
  endtask

  task automatic spawn_all(input logic [31:0] v);
    spawn_t sp;
    sp = '{px: v, py: v, vx: v, vy: v, rot: v, spin: v, sc: v};
    send(FUNC_SPAWN, sp);
  endtask

  function automatic logic [31:0] pick_value(bit near);
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return near ? 32'($signed($urandom_range(0, 2**21)) - 2**20) : $urandom;
    endcase
  endfunction

  task automatic spawn_random();
    spawn_t sp;
    sp = '{px: pick_value(1), py: pick_value(1), vx: pick_value(1),
           vy: pick_value(1), rot: pick_value(1), spin: pick_value(1),
           sc: pick_value(1)};
    send(FUNC_SPAWN, sp);
  endtask

  // stop offering, wait for all records, then a margin before touching
  // the registers
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_config(input logic [15:0] life);
    write_reg(REG_GRAVITY_X, pick_value(1));
    write_reg(REG_GRAVITY_Y, pick_value(1));
    write_reg(REG_DRAG, $urandom_range(0, 3) == 0 ? $urandom :
              {1'b0, 15'($urandom), 1'b0, 15'($urandom)});
    write_reg(REG_LIFETIME, 32'(life));
    write_reg(REG_START_COL, $urandom);
    write_reg(REG_END_COL, $urandom);
    write_reg(REG_SCALE_TGT, pick_value(1));
    write_reg(REG_SCALE_EN, $urandom_range(0, 1));
  endtask

  task automatic random_phase(input int n_items, input int spawn_pct,
                              input bit with_hold);
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 2) hold_req = 1;
      if ($urandom_range(1, 100) <= spawn_pct) spawn_random();
      else tick();
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = REG_GRAVITY_X; cfg_data = 0;
    in_valid = 0; func = FUNC_SPAWN;
    spawn_pos_x = 0; spawn_pos_y = 0; spawn_vel_x = 0; spawn_vel_y = 0;
    spawn_rotation = 0; spawn_spin = 0; spawn_scale = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    // defaults: lifetime 1, so a particle draws once and retires next tick
    spawn_all(32'h0);
    spawn_all(32'h7fff_ffff);     // saturating position and rotation
    spawn_all(32'h8000_0000);
    spawn_all(32'haaaa_aaaa);
    spawn_all(32'h5555_5555);
    tick();
    tick();                       // retires all; freed slots reused below
    spawn_all(32'h0001_0000);
    spawn_all(32'hffff_0000);
    tick();
    drain();

    // extreme settings: zero lifetime, drag above one, full gravity
    write_reg(REG_GRAVITY_X, 32'h7fff_ffff);
    write_reg(REG_GRAVITY_Y, 32'h8000_0000);
    write_reg(REG_DRAG, 32'hffff_ffff);
    write_reg(REG_LIFETIME, 32'h0);
    write_reg(REG_START_COL, 32'h00ff_00ff);
    write_reg(REG_END_COL, 32'hff00_ff00);
    write_reg(REG_SCALE_TGT, 32'h8000_0000);
    write_reg(REG_SCALE_EN, 32'h1);
    spawn_all(32'h7fff_ffff);
    spawn_all(32'h8000_0000);
    tick();
    tick();
    drain();

    // short lives (lifetime 4) with lerp steps, zero drag
    write_reg(REG_GRAVITY_X, 32'hffff_8000);
    write_reg(REG_GRAVITY_Y, 32'h0000_4000);
    write_reg(REG_DRAG, 32'h0000_0000);
    write_reg(REG_LIFETIME, 32'd4);
    write_reg(REG_SCALE_TGT, 32'h7fff_ffff);
    spawn_random();
    spawn_random();
    spawn_random();
    repeat (5) tick();
    drain();

    // random phases; the long-life one fills the pool and drops spawns
    random_config(16'($urandom_range(1, 6)));
    random_phase(25, 50, 0);
    random_config(16'hffff);
    random_phase(45, 85, 1);
    random_config(16'($urandom_range(2, 12)));
    random_phase(25, 40, 0);
    random_config(16'($urandom_range(0, 65535)));
    random_phase(20, 60, 0);

    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
